// ===== sv/polyline_parallel_offset_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Polyline parallel offset unit assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_PARALLEL_OFFSET_UNIT_MACROS_SVH
`define POLYLINE_PARALLEL_OFFSET_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPO_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PPO_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/ppo_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset package
// Types, constants and arithmetic helpers shared by the offset unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppo_pkg;

   localparam int QW = 26;
   localparam int NW = 49;
   localparam int DW = 32;

   localparam logic signed [15:0] COS_LIMIT_RESET = -16'sd32270;

   typedef enum logic [0:0] {
      CSR_OFFSET_DISTANCE   = 1'b0,
      CSR_TURN_COSINE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic sharp;
      logic overflow;
   } cmd_flags_type;

   typedef enum logic [3:0] {
      F_IDLE, F_MUL, F_SUM, F_SQRT, F_DIVX, F_DIVY, F_WDIR, F_CMP, F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_RD, B_CALC, B_END, B_DEN, B_SX, B_DIVX, B_DIVY, B_FIN, B_OUT
   } back_state_type;

   function automatic logic signed [15:0] sat_dir(input logic neg, input logic [QW-1:0] q);
      logic signed [15:0] m;
      m = (q > QW'(32767)) ? 16'sd32767 : signed'(q[15:0]);
      return neg ? -m : m;
   endfunction

   function automatic logic signed [27:0] round_q15(input logic signed [32:0] p);
      logic [32:0]        mag;
      logic [17:0]        q;
      logic signed [27:0] s;
      mag = p[32] ? 33'(-p) : 33'(p);
      q   = 18'((mag + 33'd16384) >> 15);
      s   = {10'b0, q};
      return p[32] ? -s : s;
   endfunction

   function automatic logic signed [27:0] apply_quo(input logic neg, input logic [QW-1:0] q);
      logic signed [27:0] s;
      s = {2'b0, q};
      return neg ? -s : s;
   endfunction

   function automatic logic [23:0] clamp24(input logic signed [28:0] v);
      logic [23:0] r;
      if (v > 29'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -29'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ppo_ram.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/ppo_isqrt.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset square root
// Bit-serial integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppo_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

`default_nettype wire

// ===== sv/ppo_div.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset divider
// Restoring unsigned divider, one quotient bit a cycle, saturating quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppo_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ppo_pkg::NW-1:0]    num,
   input  logic [ppo_pkg::DW-1:0]    den,
   output logic                      done,
   output logic [ppo_pkg::QW-1:0]    quo
);

   localparam int SW = ppo_pkg::QW + ppo_pkg::DW;

   logic [ppo_pkg::NW-1:0] rem_ff, rem_in;
   logic [SW-1:0]          dsh_ff, dsh_in;
   logic [ppo_pkg::QW-1:0] q_ff, q_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic                   first_ff, first_in, busy_ff, busy_in, done_ff, done_in;
   logic                   ge;

   assign ge = SW'(rem_ff) >= dsh_ff;

   always_comb begin
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = num;
         dsh_in   = {den, ppo_pkg::QW'(0)};
         q_in     = '0;
         cnt_in   = 5'(ppo_pkg::QW - 1);
         first_in = 1'b1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (first_ff) begin
            if (ge) begin
               q_in    = '1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               first_in = 1'b0;
               dsh_in   = dsh_ff >> 1;
            end
         end else begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff[ppo_pkg::NW-1:0];
            end
            q_in   = {q_ff[ppo_pkg::QW-2:0], ge};
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == 5'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

`default_nettype wire

// ===== sv/ppo_front.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset front end
// Accepts vertices, stores them, derives unit directions and the turn test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppo_front #(
   parameter int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic                  hold_accept,
   input  logic signed [15:0]    cos_limit,
   output logic                  vtx_we,
   output logic [AW-1:0]         vtx_waddr,
   output logic [47:0]           vtx_wdata,
   output logic                  dir_we,
   output logic [AW-1:0]         dir_waddr,
   output logic [31:0]           dir_wdata,
   output logic                  cmd_push,
   output logic [CW-1:0]         cmd_count,
   output ppo_pkg::cmd_flags_type cmd_flags,
   input  logic                  cmd_full
);

   ppo_pkg::front_state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 sharp_ff, sharp_in, ovf_ff, ovf_in, last_ff, last_in, k2_ff, k2_in;
   logic [AW-1:0]        kidx_ff, kidx_in;
   logic signed [23:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [15:0]   prev_ux_ff, prev_ux_in, prev_uy_ff, prev_uy_in;
   logic signed [15:0]   ux_ff, ux_in, uy_ff, uy_in;
   logic signed [24:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [48:0]          sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic signed [31:0]   dotx_ff, dotx_in, doty_ff, doty_in;

   logic                 accept, store_full;
   logic signed [23:0]   in_x, in_y;
   logic signed [49:0]   sqx_full, sqy_full;
   logic [49:0]          l2;
   logic                 sqrt_start, sqrt_done, div_start, div_done;
   logic [31:0]          sqrt_root;
   logic [24:0]          sel_mag;
   logic [ppo_pkg::NW-1:0] div_num;
   logic [ppo_pkg::QW-1:0] div_quo;
   logic signed [32:0]   dot, lim_ext;

   assign in_x       = signed'(req_tdata[23:0]);
   assign in_y       = signed'(req_tdata[47:24]);
   assign req_tready = (state_ff == ppo_pkg::F_IDLE) && !hold_accept;
   assign accept     = req_tvalid && req_tready;
   assign store_full = (count_ff == CW'(MAX_VERTICES));

   assign vtx_we    = accept && !store_full;
   assign vtx_waddr = count_ff[AW-1:0];
   assign vtx_wdata = req_tdata;
   assign dir_we    = (state_ff == ppo_pkg::F_WDIR);
   assign dir_waddr = kidx_ff - AW'(1);
   assign dir_wdata = {uy_ff, ux_ff};

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign l2       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sqrt_start = (state_ff == ppo_pkg::F_SUM) && (l2 != 50'd0);

   assign div_start = ((state_ff == ppo_pkg::F_SQRT) && sqrt_done) ||
                      ((state_ff == ppo_pkg::F_DIVX) && div_done);
   assign sel_mag   = (state_ff == ppo_pkg::F_DIVX) ?
                      (dy_ff[24] ? 25'(-dy_ff) : 25'(dy_ff)) :
                      (dx_ff[24] ? 25'(-dx_ff) : 25'(dx_ff));
   assign div_num   = ppo_pkg::NW'({sel_mag, 22'b0}) + ppo_pkg::NW'(sqrt_root >> 1);

   assign dot     = 33'(dotx_ff) + 33'(doty_ff);
   assign lim_ext = {{2{cos_limit[15]}}, cos_limit, 15'b0};

   assign cmd_push        = (state_ff == ppo_pkg::F_PUSH) && !cmd_full;
   assign cmd_count       = count_ff;
   assign cmd_flags.sharp    = sharp_ff;
   assign cmd_flags.overflow = ovf_ff;

   ppo_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({l2, 14'b0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   ppo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (sqrt_root),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      sharp_in   = sharp_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;
      k2_in      = k2_ff;
      kidx_in    = kidx_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      prev_ux_in = prev_ux_ff;
      prev_uy_in = prev_uy_ff;
      ux_in      = ux_ff;
      uy_in      = uy_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sqx_in     = sqx_ff;
      sqy_in     = sqy_ff;
      dotx_in    = dotx_ff;
      doty_in    = doty_ff;
      unique case (state_ff)
         ppo_pkg::F_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (store_full) begin
                  ovf_in   = 1'b1;
                  state_in = req_tlast ? ppo_pkg::F_PUSH : ppo_pkg::F_IDLE;
               end else begin
                  count_in  = count_ff + CW'(1);
                  kidx_in   = count_ff[AW-1:0];
                  k2_in     = (count_ff >= CW'(2));
                  prev_x_in = in_x;
                  prev_y_in = in_y;
                  dx_in     = 25'(in_x) - 25'(prev_x_ff);
                  dy_in     = 25'(in_y) - 25'(prev_y_ff);
                  if (count_ff == CW'(0)) begin
                     state_in = req_tlast ? ppo_pkg::F_PUSH : ppo_pkg::F_IDLE;
                  end else begin
                     state_in = ppo_pkg::F_MUL;
                  end
               end
            end
         end
         ppo_pkg::F_MUL: begin
            sqx_in   = sqx_full[48:0];
            sqy_in   = sqy_full[48:0];
            state_in = ppo_pkg::F_SUM;
         end
         ppo_pkg::F_SUM: begin
            if (l2 == 50'd0) begin
               ux_in    = '0;
               uy_in    = '0;
               state_in = ppo_pkg::F_WDIR;
            end else begin
               state_in = ppo_pkg::F_SQRT;
            end
         end
         ppo_pkg::F_SQRT: begin
            if (sqrt_done) begin
               state_in = ppo_pkg::F_DIVX;
            end
         end
         ppo_pkg::F_DIVX: begin
            if (div_done) begin
               ux_in    = ppo_pkg::sat_dir(dx_ff[24], div_quo);
               state_in = ppo_pkg::F_DIVY;
            end
         end
         ppo_pkg::F_DIVY: begin
            if (div_done) begin
               uy_in    = ppo_pkg::sat_dir(dy_ff[24], div_quo);
               state_in = ppo_pkg::F_WDIR;
            end
         end
         ppo_pkg::F_WDIR: begin
            dotx_in  = ux_ff * prev_ux_ff;
            doty_in  = uy_ff * prev_uy_ff;
            state_in = ppo_pkg::F_CMP;
         end
         ppo_pkg::F_CMP: begin
            if (k2_ff && (dot < lim_ext)) begin
               sharp_in = 1'b1;
            end
            prev_ux_in = ux_ff;
            prev_uy_in = uy_ff;
            state_in   = last_ff ? ppo_pkg::F_PUSH : ppo_pkg::F_IDLE;
         end
         ppo_pkg::F_PUSH: begin
            if (!cmd_full) begin
               count_in = '0;
               sharp_in = 1'b0;
               ovf_in   = 1'b0;
               state_in = ppo_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = ppo_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppo_pkg::F_IDLE;
         count_ff <= '0;
         sharp_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sharp_ff <= sharp_in;
         ovf_ff   <= ovf_in;
      end
      last_ff    <= last_in;
      k2_ff      <= k2_in;
      kidx_ff    <= kidx_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      prev_ux_ff <= prev_ux_in;
      prev_uy_ff <= prev_uy_in;
      ux_ff      <= ux_in;
      uy_ff      <= uy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      dotx_ff    <= dotx_in;
      doty_ff    <= doty_in;
   end

endmodule

`default_nettype wire

// ===== sv/ppo_back.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset back end
// Walks the stored path and emits the offset or the unchanged vertices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppo_back #(
   parameter int MAX_VERTICES = 64,
   localparam int AW = $clog2(MAX_VERTICES),
   localparam int CW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  logic [CW-1:0]         cmd_count,
   input  ppo_pkg::cmd_flags_type cmd_flags,
   output logic                  cmd_pop,
   output logic [AW-1:0]         rd_addr,
   input  logic [47:0]           vtx_rdata,
   input  logic [31:0]           dir_rdata,
   input  logic signed [15:0]    offset_distance,
   output logic                  busy,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   ppo_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]        n_ff, n_in, k_ff, k_in;
   logic                 pass_ff, pass_in, ovf_ff, ovf_in, lastv_ff, lastv_in;
   logic signed [23:0]   vx_ff, vx_in, vy_ff, vy_in;
   logic signed [15:0]   cdx_ff, cdx_in, cdy_ff, cdy_in, pdx_ff, pdx_in, pdy_ff, pdy_in;
   logic signed [31:0]   dot1_ff, dot1_in, dot2_ff, dot2_in;
   logic signed [32:0]   mx_ff, mx_in, my_ff, my_in;
   logic [31:0]          den_ff, den_in;
   logic signed [27:0]   subx_ff, subx_in, addy_ff, addy_in;
   logic [23:0]          rx_ff, rx_in, ry_ff, ry_in;
   logic                 rpass_ff, rpass_in, rovf_ff, rovf_in, rlast_ff, rlast_in;
   logic                 rvalid_ff, rvalid_in;

   logic signed [15:0]   rd_dx, rd_dy, sel_dx, sel_dy;
   logic signed [31:0]   end_px, end_py;
   logic signed [16:0]   sx, sy;
   logic signed [32:0]   inner_mx, inner_my;
   logic signed [33:0]   den_full;
   logic                 div_start, div_done;
   logic [32:0]          sel_mag;
   logic [ppo_pkg::NW-1:0] div_num;
   logic [ppo_pkg::QW-1:0] div_quo;

   assign rd_addr = k_ff[AW-1:0];
   assign rd_dx   = signed'(dir_rdata[15:0]);
   assign rd_dy   = signed'(dir_rdata[31:16]);
   assign sel_dx  = (k_ff == CW'(0)) ? rd_dx : pdx_ff;
   assign sel_dy  = (k_ff == CW'(0)) ? rd_dy : pdy_ff;
   assign end_px  = offset_distance * sel_dy;
   assign end_py  = offset_distance * sel_dx;
   assign sx      = 17'(cdx_ff) + 17'(pdx_ff);
   assign sy      = 17'(cdy_ff) + 17'(pdy_ff);
   assign inner_mx = offset_distance * sy;
   assign inner_my = offset_distance * sx;
   assign den_full = 34'sd1073741824 + 34'(dot1_ff) + 34'(dot2_ff);

   assign div_start = (state_ff == ppo_pkg::B_SX) ||
                      ((state_ff == ppo_pkg::B_DIVX) && div_done);
   assign sel_mag   = (state_ff == ppo_pkg::B_SX) ?
                      (mx_ff[32] ? 33'(-mx_ff) : 33'(mx_ff)) :
                      (my_ff[32] ? 33'(-my_ff) : 33'(my_ff));
   assign div_num   = ppo_pkg::NW'({sel_mag, 15'b0}) + ppo_pkg::NW'(den_ff >> 1);

   assign cmd_pop    = (state_ff == ppo_pkg::B_IDLE) && cmd_valid;
   assign busy       = (state_ff != ppo_pkg::B_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {ry_ff, rx_ff};
   assign rsp_tuser  = {rovf_ff, rpass_ff};
   assign rsp_tlast  = rlast_ff;

   ppo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      pass_in   = pass_ff;
      ovf_in    = ovf_ff;
      lastv_in  = lastv_ff;
      vx_in     = vx_ff;
      vy_in     = vy_ff;
      cdx_in    = cdx_ff;
      cdy_in    = cdy_ff;
      pdx_in    = pdx_ff;
      pdy_in    = pdy_ff;
      dot1_in   = dot1_ff;
      dot2_in   = dot2_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      den_in    = den_ff;
      subx_in   = subx_ff;
      addy_in   = addy_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rpass_in  = rpass_ff;
      rovf_in   = rovf_ff;
      rlast_in  = rlast_ff;
      rvalid_in = rvalid_ff;
      unique case (state_ff)
         ppo_pkg::B_IDLE: begin
            if (cmd_valid) begin
               n_in     = cmd_count;
               k_in     = '0;
               pass_in  = cmd_flags.sharp || (cmd_count <= CW'(1));
               ovf_in   = cmd_flags.overflow;
               state_in = ppo_pkg::B_RD;
            end
         end
         ppo_pkg::B_RD: begin
            state_in = ppo_pkg::B_CALC;
         end
         ppo_pkg::B_CALC: begin
            vx_in    = signed'(vtx_rdata[23:0]);
            vy_in    = signed'(vtx_rdata[47:24]);
            cdx_in   = rd_dx;
            cdy_in   = rd_dy;
            lastv_in = (k_ff == n_ff - CW'(1));
            mx_in    = 33'(end_px);
            my_in    = 33'(end_py);
            dot1_in  = rd_dx * pdx_ff;
            dot2_in  = rd_dy * pdy_ff;
            if (pass_ff) begin
               subx_in  = '0;
               addy_in  = '0;
               state_in = ppo_pkg::B_FIN;
            end else if ((k_ff == CW'(0)) || (k_ff == n_ff - CW'(1))) begin
               state_in = ppo_pkg::B_END;
            end else begin
               state_in = ppo_pkg::B_DEN;
            end
         end
         ppo_pkg::B_END: begin
            subx_in  = ppo_pkg::round_q15(mx_ff);
            addy_in  = ppo_pkg::round_q15(my_ff);
            state_in = ppo_pkg::B_FIN;
         end
         ppo_pkg::B_DEN: begin
            den_in   = (den_full < 34'sd1) ? 32'd1 : den_full[31:0];
            mx_in    = inner_mx;
            my_in    = inner_my;
            state_in = ppo_pkg::B_SX;
         end
         ppo_pkg::B_SX: begin
            state_in = ppo_pkg::B_DIVX;
         end
         ppo_pkg::B_DIVX: begin
            if (div_done) begin
               subx_in  = ppo_pkg::apply_quo(mx_ff[32], div_quo);
               state_in = ppo_pkg::B_DIVY;
            end
         end
         ppo_pkg::B_DIVY: begin
            if (div_done) begin
               addy_in  = ppo_pkg::apply_quo(my_ff[32], div_quo);
               state_in = ppo_pkg::B_FIN;
            end
         end
         ppo_pkg::B_FIN: begin
            rx_in     = ppo_pkg::clamp24(29'(vx_ff) - 29'(subx_ff));
            ry_in     = ppo_pkg::clamp24(29'(vy_ff) + 29'(addy_ff));
            rpass_in  = pass_ff;
            rovf_in   = ovf_ff;
            rlast_in  = lastv_ff;
            rvalid_in = 1'b1;
            state_in  = ppo_pkg::B_OUT;
         end
         ppo_pkg::B_OUT: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               pdx_in    = cdx_ff;
               pdy_in    = cdy_ff;
               k_in      = k_ff + CW'(1);
               state_in  = lastv_ff ? ppo_pkg::B_IDLE : ppo_pkg::B_RD;
            end
         end
         default: begin
            state_in = ppo_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ppo_pkg::B_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
      n_ff     <= n_in;
      k_ff     <= k_in;
      pass_ff  <= pass_in;
      ovf_ff   <= ovf_in;
      lastv_ff <= lastv_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      cdx_ff   <= cdx_in;
      cdy_ff   <= cdy_in;
      pdx_ff   <= pdx_in;
      pdy_ff   <= pdy_in;
      dot1_ff  <= dot1_in;
      dot2_ff  <= dot2_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      den_ff   <= den_in;
      subx_ff  <= subx_in;
      addy_ff  <= addy_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rpass_ff <= rpass_in;
      rovf_ff  <= rovf_in;
      rlast_ff <= rlast_in;
   end

endmodule

`default_nettype wire

// ===== sv/polyline_parallel_offset_unit.sv =====
// A vertex after the first runs one 32-step square root and two 27-step divisions in the front
// end, unless its segment has zero length; the first vertex and dropped vertices skip these.
// Emission: inner vertices need two divisions in the back end, end vertices only a rounding step.
// A new path is accepted only after the back end has emitted the previous one.
// Reset is synchronous and active high; it clears counts and flags and returns the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Polyline parallel offset unit
// Stores a polyline vertex by vertex and emits its miter-joined parallel offset, or passes
// its vertices unchanged when a turn is sharp or the path has at most one vertex.
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_parallel_offset_unit_macros.svh"

module polyline_parallel_offset_unit #(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // vertex_x[23:0], vertex_y[47:24]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_x[23:0], out_y[47:24]
   output logic [1:0]  rsp_tuser,   // passed_unchanged[0], overflow[1]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic signed [15:0] offset_ff, cos_ff;

   logic              vtx_we, dir_we, cmd_push, cmd_pop, back_busy, hold_accept;
   logic [AW-1:0]     vtx_waddr, dir_waddr, rd_addr;
   logic [47:0]       vtx_wdata, vtx_rdata;
   logic [31:0]       dir_wdata, dir_rdata;
   logic [CW-1:0]     push_count;
   ppo_pkg::cmd_flags_type push_flags;

   logic [CW-1:0]     q_count_ff [2];
   ppo_pkg::cmd_flags_type q_flags_ff [2];
   logic              q_wp_ff, q_rp_ff;
   logic [1:0]        q_fill_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         cos_ff    <= ppo_pkg::COS_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (ppo_pkg::csr_index_type'(csr_index))
            ppo_pkg::CSR_OFFSET_DISTANCE:   offset_ff <= signed'(csr_data);
            ppo_pkg::CSR_TURN_COSINE_LIMIT: cos_ff    <= signed'(csr_data);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff   <= 1'b0;
         q_rp_ff   <= 1'b0;
         q_fill_ff <= '0;
      end else begin
         if (cmd_push) begin
            q_wp_ff <= ~q_wp_ff;
         end
         if (cmd_pop) begin
            q_rp_ff <= ~q_rp_ff;
         end
         q_fill_ff <= q_fill_ff + 2'(cmd_push) - 2'(cmd_pop);
      end
      if (cmd_push) begin
         q_count_ff[q_wp_ff] <= push_count;
         q_flags_ff[q_wp_ff] <= push_flags;
      end
   end

   assign hold_accept = back_busy || (q_fill_ff != 2'd0);

   ppo_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock (clock),
      .we    (vtx_we),
      .waddr (vtx_waddr),
      .wdata (vtx_wdata),
      .raddr (rd_addr),
      .rdata (vtx_rdata)
   );

   ppo_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .raddr (rd_addr),
      .rdata (dir_rdata)
   );

   ppo_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .hold_accept (hold_accept),
      .cos_limit   (cos_ff),
      .vtx_we      (vtx_we),
      .vtx_waddr   (vtx_waddr),
      .vtx_wdata   (vtx_wdata),
      .dir_we      (dir_we),
      .dir_waddr   (dir_waddr),
      .dir_wdata   (dir_wdata),
      .cmd_push    (cmd_push),
      .cmd_count   (push_count),
      .cmd_flags   (push_flags),
      .cmd_full    (q_fill_ff == 2'd2)
   );

   ppo_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_fill_ff != 2'd0),
      .cmd_count       (q_count_ff[q_rp_ff]),
      .cmd_flags       (q_flags_ff[q_rp_ff]),
      .cmd_pop         (cmd_pop),
      .rd_addr         (rd_addr),
      .vtx_rdata       (vtx_rdata),
      .dir_rdata       (dir_rdata),
      .offset_distance (offset_ff),
      .busy            (back_busy),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

   `PPO_ASSERT_IMPLY(a_accept_back_idle, req_tready, !back_busy && (q_fill_ff == 2'd0))
   `PPO_ASSERT_IMPLY(a_push_has_room, cmd_push, q_fill_ff != 2'd2)
   `PPO_ASSERT_IMPLY(a_rsp_from_busy_back, rsp_tvalid, back_busy)
   `PPO_ASSERT_NEXT(a_pop_starts_walk, cmd_pop, back_busy && !req_tready)

endmodule

`default_nettype wire

// ===== sim/polyline_parallel_offset_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Polyline parallel offset unit testbench
// Streams polylines vertex by vertex into the offset unit, predicts every
// emitted vertex with a behavioral model of the miter-join offset and checks
// the results field by field, under random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyline_parallel_offset_unit_tb;

   localparam int MAX_VERTS = 64;
   localparam int WATCHDOG_LIMIT = 200000;

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic               last;
   } vertex_item_type;

   typedef struct {
      logic [23:0] x;
      logic [23:0] y;
      logic        pass;
      logic        ovf;
      logic        last;
   } offset_vertex_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   polyline_parallel_offset_unit dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   longint vx [MAX_VERTS];
   longint vy [MAX_VERTS];
   longint ux_s [MAX_VERTS];
   longint uy_s [MAX_VERTS];
   int     n_verts = 0;
   bit     sharp = 0;
   bit     ovf = 0;
   longint offset_dist = 0;
   longint cos_lim = -32270;

   vertex_item_type   pending_vertices[$];
   offset_vertex_type expected_vertices[$];
   int  errors = 0;
   int  accepted_in = 0;
   int  accepted_out = 0;
   int  paths_done = 0;
   int  watchdog = 0;
   bit  idle_free = 0;
   bit  hold_sender = 0;

   function automatic longint rdiv(longint num, longint den);
      longint m, q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint isqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sh4000000000000000;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   function automatic longint clamp_dir(longint v);
      return v > 32767 ? 32767 : (v < -32767 ? -32767 : v);
   endfunction

   function automatic logic [23:0] sat24(longint v);
      longint c;
      c = v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
      return c[23:0];
   endfunction

   task automatic push_offset_vertex(longint x, longint y, bit pass, bit last);
      offset_vertex_type r;
      r.x = sat24(x);
      r.y = sat24(y);
      r.pass = pass;
      r.ovf = ovf;
      r.last = last;
      expected_vertices.push_back(r);
   endtask

   task automatic predict_offset(vertex_item_type it);
      longint dx, dy, l2, len, ux, uy, dot, den, sx, sy;
      int k, n;
      k = n_verts;
      if (k >= MAX_VERTS) begin
         ovf = 1;
      end else begin
         vx[k] = it.x;
         vy[k] = it.y;
         if (k >= 1) begin
            dx = vx[k] - vx[k-1];
            dy = vy[k] - vy[k-1];
            l2 = dx * dx + dy * dy;
            ux = 0;
            uy = 0;
            if (l2 != 0) begin
               len = isqrt(l2 << 14);
               ux = clamp_dir(rdiv(dx * 4194304, len));
               uy = clamp_dir(rdiv(dy * 4194304, len));
            end
            ux_s[k-1] = ux;
            uy_s[k-1] = uy;
            if (k >= 2) begin
               dot = ux * ux_s[k-2] + uy * uy_s[k-2];
               if (dot < cos_lim * 32768) sharp = 1;
            end
         end
         n_verts = k + 1;
      end
      if (!it.last) return;
      n = n_verts;
      if (n <= 1 || sharp) begin
         for (int i = 0; i < n; i++) push_offset_vertex(vx[i], vy[i], 1, i == n - 1);
      end else begin
         push_offset_vertex(vx[0] - rdiv(offset_dist * uy_s[0], 32768),
                            vy[0] + rdiv(offset_dist * ux_s[0], 32768), 0, 0);
         for (int i = 1; i < n - 1; i++) begin
            dot = ux_s[i] * ux_s[i-1] + uy_s[i] * uy_s[i-1];
            den = (64'sd1 << 30) + dot;
            sx = ux_s[i] + ux_s[i-1];
            sy = uy_s[i] + uy_s[i-1];
            if (den < 1) den = 1;
            push_offset_vertex(vx[i] - rdiv(offset_dist * sy * 32768, den),
                               vy[i] + rdiv(offset_dist * sx * 32768, den), 0, 0);
         end
         push_offset_vertex(vx[n-1] - rdiv(offset_dist * uy_s[n-2], 32768),
                            vy[n-1] + rdiv(offset_dist * ux_s[n-2], 32768), 0, 1);
      end
      n_verts = 0;
      sharp = 0;
      ovf = 0;
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_offset(pending_vertices.pop_front());
            accepted_in++;
         end
         if (pending_vertices.size() != 0 && !hold_sender
             && (idle_free || $urandom_range(99) >= 26)) begin
            req_tvalid <= 1'b1;
            req_tdata <= {pending_vertices[0].y, pending_vertices[0].x};
            req_tlast <= pending_vertices[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            accepted_out++;
            if (expected_vertices.size() == 0) begin
               $error("unexpected result x=%h y=%h", rsp_tdata[23:0], rsp_tdata[47:24]);
               errors++;
            end else begin
               offset_vertex_type e;
               e = expected_vertices.pop_front();
               if (rsp_tdata[23:0] !== e.x) begin
                  $error("out_x expected %h actual %h", e.x, rsp_tdata[23:0]);
                  errors++;
               end
               if (rsp_tdata[47:24] !== e.y) begin
                  $error("out_y expected %h actual %h", e.y, rsp_tdata[47:24]);
                  errors++;
               end
               if (rsp_tuser[0] !== e.pass) begin
                  $error("passed_unchanged expected %0d actual %0d", e.pass, rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tuser[1] !== e.ovf) begin
                  $error("overflow expected %0d actual %0d", e.ovf, rsp_tuser[1]);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_out expected %0d actual %0d", e.last, rsp_tlast);
                  errors++;
               end
               if (e.last) paths_done++;
            end
         end
         rsp_tready <= idle_free || $urandom_range(99) >= 26;
      end
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("FAIL polyline_parallel_offset_unit");
         $finish;
      end
   end

   task automatic write_reg(ppo_pkg::csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ppo_pkg::CSR_OFFSET_DISTANCE) offset_dist = longint'(signed'(value));
      else cos_lim = longint'(signed'(value));
   endtask

   task automatic wait_drained();
      while (pending_vertices.size() != 0 || req_tvalid || expected_vertices.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic add_vertex(longint x, longint y, bit last);
      vertex_item_type it;
      it.x = x[23:0];
      it.y = y[23:0];
      it.last = last;
      pending_vertices.push_back(it);
   endtask

   function automatic longint rnd24();
      return longint'(signed'(24'($urandom)));
   endfunction

   // Random path, mostly well behaved with occasional extreme vertices.
   task automatic add_random_path(int len);
      longint x, y;
      x = $signed($urandom_range(20000)) - 10000;
      y = $signed($urandom_range(20000)) - 10000;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            x = rnd24();
            y = rnd24();
         end else begin
            x = x + $signed($urandom_range(8000)) - 4000;
            y = y + $signed($urandom_range(8000)) - 4000;
         end
         add_vertex(x, y, i == len - 1);
      end
   endtask

   initial begin
      logic [15:0] dists [4];
      logic [15:0] limits [4];
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: single vertex, extremes, zero-length and sharp turns.
      write_reg(ppo_pkg::CSR_OFFSET_DISTANCE, 16'sd2560);
      add_vertex(8388607, -8388608, 1);
      add_vertex(0, 0, 0);
      add_vertex(2560, 0, 0);
      add_vertex(2560, 2560, 1);
      add_vertex(100, 100, 0);
      add_vertex(100, 100, 0);
      add_vertex(5000, 100, 1);
      add_vertex(0, 0, 0);
      add_vertex(5000, 0, 0);
      add_vertex(0, 10, 1);
      add_vertex(-8388608, -8388608, 0);
      add_vertex(8388607, 8388607, 0);
      add_vertex(-8388608, 8388607, 1);
      wait_drained();

      // Near-reversal turn giving a tiny miter denominator, full offset range.
      write_reg(ppo_pkg::CSR_OFFSET_DISTANCE, 16'h7FFF);
      write_reg(ppo_pkg::CSR_TURN_COSINE_LIMIT, 16'h8000);
      add_vertex(0, 0, 0);
      add_vertex(100000, 0, 0);
      add_vertex(0, 1, 1);
      wait_drained();

      // Capacity overflow, the last vertex dropped too.
      write_reg(ppo_pkg::CSR_OFFSET_DISTANCE, 16'h8000);
      for (int i = 0; i < MAX_VERTS + 3; i++)
         add_vertex(i * 300, (i % 2) * 200, i == MAX_VERTS + 2);
      wait_drained();

      // Pause the sender after one path until all of its results have come back.
      add_random_path(6);
      add_random_path(5);
      while (pending_vertices.size() > 5) @(posedge clock);
      hold_sender = 1;
      while (expected_vertices.size() != 0 || req_tvalid) @(posedge clock);
      hold_sender = 0;
      wait_drained();

      dists = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0100};
      limits = '{16'h8000, 16'h7FFF, 16'h8200, 16'h0000};
      for (int ph = 0; ph < 6; ph++) begin
         idle_free = (ph == 2);
         write_reg(ppo_pkg::CSR_OFFSET_DISTANCE, ph < 4 ? dists[ph] : 16'($urandom));
         write_reg(ppo_pkg::CSR_TURN_COSINE_LIMIT, ph < 4 ? limits[ph] : 16'($urandom));
         for (int p = 0; p < 3; p++) add_random_path($urandom_range(1, 10));
         wait_drained();
      end
      idle_free = 0;

      $display("Covered %0d vertices in, %0d offset vertices out over %0d paths.",
               accepted_in, accepted_out, paths_done);
      if (errors == 0) begin
         $display("PASS polyline_parallel_offset_unit");
      end else begin
         $display("FAIL polyline_parallel_offset_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/ppo_pkg.sv
sv/ppo_ram.sv
sv/ppo_isqrt.sv
sv/ppo_div.sv
sv/ppo_front.sv
sv/ppo_back.sv
sv/polyline_parallel_offset_unit.sv
sim/polyline_parallel_offset_unit_tb.sv
